// ----- src/i8mm_pkg.sv -----
`timescale 1ns / 1ps

package i8mm_pkg;

    localparam int ELEM_W     = 8;
    localparam int INDEX_W    = 6;
    localparam int SUM_W      = 22;
    localparam int SUM_MAX    = 2 ** (SUM_W - 1) - 1;
    localparam int SUM_MIN    = -(2 ** (SUM_W - 1));
    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    // power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [4:0] NUM_ROWS_RESET    = 5'd16;
    localparam logic [4:0] NUM_COLS_RESET    = 5'd16;
    localparam logic [6:0] INNER_DEPTH_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_NUM_ROWS    = 2'd0,
        REG_NUM_COLS    = 2'd1,
        REG_INNER_DEPTH = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_COMPUTE,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [4:0] num_rows;
        logic [4:0] num_cols;
        logic [6:0] inner_depth;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                command;
        logic [INDEX_W-1:0]        row_index;
        logic [INDEX_W-1:0]        col_index;
        logic signed [ELEM_W-1:0]  element;
    } request_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] dot_sum;
        logic                    index_error;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
        logic [ELEM_W-1:0]  element;
    } job_t;

endpackage

// ----- src/i8mm_ram.sv -----
`timescale 1ns / 1ps

module i8mm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/i8mm_front.sv -----
`timescale 1ns / 1ps

module i8mm_front #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_DEPTH = 64
) (
    input  i8mm_pkg::cfg_t     cfg,
    input  logic               start,
    input  i8mm_pkg::request_t request,
    input  logic               full,
    output logic               busy,
    output logic               push,
    output i8mm_pkg::job_t     job
);

    import i8mm_pkg::*;

    logic accept;
    logic row_in_rows;
    logic row_in_depth;
    logic col_in_cols;
    logic col_in_depth;
    logic keep;

    assign busy   = full;
    assign accept = start && !full;

    assign row_in_rows  = (int'(request.row_index) < int'(cfg.num_rows))
                          && (int'(request.row_index) < MAX_ROWS);
    assign row_in_depth = (int'(request.row_index) < int'(cfg.inner_depth))
                          && (int'(request.row_index) < MAX_DEPTH);
    assign col_in_cols  = (int'(request.col_index) < int'(cfg.num_cols))
                          && (int'(request.col_index) < MAX_COLS);
    assign col_in_depth = (int'(request.col_index) < int'(cfg.inner_depth))
                          && (int'(request.col_index) < MAX_DEPTH);

    always_comb
    begin
        keep        = 1'b0;
        job.op      = OP_ERROR;
        job.row     = request.row_index;
        job.col     = request.col_index;
        job.element = request.element;
        unique case (cmd_t'(request.command))
            CMD_LOAD_A:
            begin
                keep   = row_in_rows && col_in_depth;
                job.op = OP_LOAD_A;
            end
            CMD_LOAD_B:
            begin
                keep   = row_in_depth && col_in_cols;
                job.op = OP_LOAD_B;
            end
            CMD_COMPUTE:
            begin
                keep   = 1'b1;
                job.op = (row_in_rows && col_in_cols) ? OP_COMPUTE : OP_ERROR;
            end
            CMD_NONE:
            begin
                keep = 1'b0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

endmodule

// ----- src/i8mm_queue.sv -----
`timescale 1ns / 1ps

module i8mm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  i8mm_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output i8mm_pkg::job_t head
);

    import i8mm_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- src/i8mm_back.sv -----
`timescale 1ns / 1ps

module i8mm_back #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  i8mm_pkg::cfg_t    cfg,
    input  logic              job_valid,
    input  i8mm_pkg::job_t    job,
    output logic              job_pop,
    output logic              done,
    output i8mm_pkg::result_t result
);

    import i8mm_pkg::*;

    localparam int DW      = (MAX_DEPTH + LANES - 1) / LANES;
    localparam int WORD_W  = (DW > 1) ? $clog2(DW) : 1;
    localparam int WCNT_W  = $clog2(DW + 1);
    localparam int A_DEPTH = MAX_ROWS * DW;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_DEPTH = DW * MAX_COLS;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int DEPTH_W = ($clog2(MAX_DEPTH + 1) > 7) ? $clog2(MAX_DEPTH + 1) : 7;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int WSUM_W  = PROD_W + LANE_W;
    localparam int ACC_W   = WSUM_W + WCNT_W;
    localparam int SAT_W   = (ACC_W > SUM_W) ? ACC_W : SUM_W;

    back_state_t state_reg;
    back_state_t state_next;

    logic [WORD_W-1:0]  word_reg;
    logic [WORD_W-1:0]  word_next;
    logic [WORD_W-1:0]  last_reg;
    logic [WORD_W-1:0]  last_next;
    logic [LANE_W-1:0]  tail_reg;
    logic [LANE_W-1:0]  tail_next;
    logic [INDEX_W-1:0] row_reg;
    logic [INDEX_W-1:0] row_next;
    logic [INDEX_W-1:0] col_reg;
    logic [INDEX_W-1:0] col_next;

    logic                     v1_reg;
    logic                     v2_reg;
    logic [LANES-1:0]         mask1_reg;
    logic [LANES-1:0]         mask_issue;
    logic signed [PROD_W-1:0] prod_reg  [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES];
    logic signed [WSUM_W-1:0] word_sum;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SAT_W-1:0]  acc_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    logic              issue;
    logic              acc_clear;
    logic              done_reg;
    logic              done_next;
    result_t           result_reg;
    result_t           result_next;

    logic [DEPTH_W-1:0] depth_eff;
    logic [DEPTH_W:0]   depth_up;
    logic [WCNT_W-1:0]  nwords;

    logic [LANES-1:0]        a_we;
    logic [LANES-1:0]        b_we;
    logic [A_AW-1:0]         a_waddr;
    logic [A_AW-1:0]         a_raddr;
    logic [B_AW-1:0]         b_waddr;
    logic [B_AW-1:0]         b_raddr;
    logic signed [ELEM_W-1:0] a_rdata [LANES];
    logic signed [ELEM_W-1:0] b_rdata [LANES];

    assign depth_eff = (DEPTH_W'(cfg.inner_depth) > DEPTH_W'(MAX_DEPTH))
                       ? DEPTH_W'(MAX_DEPTH) : DEPTH_W'(cfg.inner_depth);
    assign depth_up  = {1'b0, depth_eff} + (DEPTH_W + 1)'(LANES - 1);
    assign nwords    = WCNT_W'(depth_up >> LANE_W);

    // A: row m, word k/4, lane k%4.  B: word k/4, column n, lane k%4.
    assign a_waddr = A_AW'(int'(job.row) * DW + int'(job.col >> LANE_W));
    assign b_waddr = B_AW'(int'(job.row >> LANE_W) * MAX_COLS + int'(job.col));
    assign a_raddr = A_AW'(int'(row_reg) * DW + int'(word_reg));
    assign b_raddr = B_AW'(int'(word_reg) * MAX_COLS + int'(col_reg));

    genvar l;
    generate
        for (l = 0; l < LANES; l++)
        begin : g_lane
            i8mm_ram #(
                .WIDTH (ELEM_W),
                .DEPTH (A_DEPTH)
            ) u_a_ram (
                .clk   (clk),
                .we    (a_we[l]),
                .waddr (a_waddr),
                .wdata (job.element),
                .raddr (a_raddr),
                .rdata (a_rdata[l])
            );

            i8mm_ram #(
                .WIDTH (ELEM_W),
                .DEPTH (B_DEPTH)
            ) u_b_ram (
                .clk   (clk),
                .we    (b_we[l]),
                .waddr (b_waddr),
                .wdata (job.element),
                .raddr (b_raddr),
                .rdata (b_rdata[l])
            );

            assign mask_issue[l] = (word_reg != last_reg) || (tail_reg == '0)
                                   || (LANE_W'(l) < tail_reg);
            assign prod_next[l]  = mask1_reg[l]
                                   ? PROD_W'(a_rdata[l]) * PROD_W'(b_rdata[l])
                                   : PROD_W'(0);
        end
    endgenerate

    always_comb
    begin
        word_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            word_sum = word_sum + WSUM_W'(prod_reg[i]);
        end
    end

    assign acc_wide = SAT_W'(acc_reg);

    always_comb
    begin
        if (acc_wide > SAT_W'(SUM_MAX))
        begin
            sum_sat = SUM_W'(SUM_MAX);
        end
        else if (acc_wide < SAT_W'(SUM_MIN))
        begin
            sum_sat = SUM_W'(SUM_MIN);
        end
        else
        begin
            sum_sat = SUM_W'(acc_wide);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        tail_next   = tail_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        issue       = 1'b0;
        acc_clear   = 1'b0;
        job_pop     = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        a_we        = '0;
        b_we        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    unique case (job.op)
                        OP_LOAD_A:
                        begin
                            a_we[job.col[LANE_W-1:0]] = 1'b1;
                        end
                        OP_LOAD_B:
                        begin
                            b_we[job.row[LANE_W-1:0]] = 1'b1;
                        end
                        OP_ERROR:
                        begin
                            done_next   = 1'b1;
                            result_next = '{dot_sum: '0, index_error: 1'b1};
                        end
                        OP_COMPUTE:
                        begin
                            if (depth_eff == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '{dot_sum: '0, index_error: 1'b0};
                            end
                            else
                            begin
                                row_next   = job.row;
                                col_next   = job.col;
                                word_next  = '0;
                                last_next  = WORD_W'(nwords - 1'b1);
                                tail_next  = depth_eff[LANE_W-1:0];
                                acc_clear  = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                            job_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                issue     = 1'b1;
                word_next = word_reg + 1'b1;
                if (word_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{dot_sum: sum_sat, index_error: 1'b0};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            word_reg  <= '0;
            last_reg  <= '0;
            tail_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            last_reg  <= last_next;
            tail_reg  <= tail_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            done_reg  <= done_next;
            if (acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(word_sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        mask1_reg  <= mask_issue;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((a_we != '0) || (b_we != '0)) |-> (state_reg == ST_IDLE))
        else $error("store written during a compute");

    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (word_reg <= last_reg))
        else $error("word counter past last word");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && !v1_reg && !v2_reg) |=> done)
        else $error("drained compute gave no result");

    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> ((state_reg == ST_RUN) || (state_reg == ST_DRAIN)))
        else $error("products in flight outside a compute");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.index_error) |-> (result.dot_sum == '0))
        else $error("index error with non-zero sum");

endmodule

// ----- src/int8_matrix_multiply.sv -----
`timescale 1ns / 1ps

// channel   handshake                          payload
// config    psel/penable/pwrite, pready high   paddr, pwdata, prdata
// request   start, transfer when !busy         request (command, row, col, element)
// result    done, one cycle                    result (dot_sum, index_error)
//
// Load: written into the A/B stores on dequeue. Compute: the four-lane A/B RAM read loop walks
// ceil(depth/4) words through the RAM read, product and accumulate registers, then gives done.
// Error and zero-depth computes give done straight from the dequeue. Queue holds two transfers; busy when full.
// Reset clears control and config; A/B stores hold garbage until written.
// done is not held off: the receiver takes each result in its cycle.

module int8_matrix_multiply #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [i8mm_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [i8mm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [i8mm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  start,
    output logic                                  busy,
    input  i8mm_pkg::request_t                    request,
    output logic                                  done,
    output i8mm_pkg::result_t                     result
);

    import i8mm_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_write;
    reg_idx_t reg_idx;

    logic     q_full;
    logic     q_push;
    job_t     q_push_job;
    logic     q_valid;
    job_t     q_head;
    logic     q_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_rows    <= NUM_ROWS_RESET;
            cfg_reg.num_cols    <= NUM_COLS_RESET;
            cfg_reg.inner_depth <= INNER_DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_NUM_ROWS:    cfg_reg.num_rows    <= pwdata[4:0];
                REG_NUM_COLS:    cfg_reg.num_cols    <= pwdata[4:0];
                REG_INNER_DEPTH: cfg_reg.inner_depth <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_NUM_ROWS:    prdata = APB_DATA_W'(cfg_reg.num_rows);
            REG_NUM_COLS:    prdata = APB_DATA_W'(cfg_reg.num_cols);
            REG_INNER_DEPTH: prdata = APB_DATA_W'(cfg_reg.inner_depth);
            default:         prdata = '0;
        endcase
    end

    i8mm_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .cfg     (cfg_reg),
        .start   (start),
        .request (request),
        .full    (q_full),
        .busy    (busy),
        .push    (q_push),
        .job     (q_push_job)
    );

    i8mm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    i8mm_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_valid),
        .job       (q_head),
        .job_pop   (q_pop),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- tb/sv/i8mm_dot_checker.sv -----
`timescale 1ns / 1ps

module i8mm_dot_checker #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [i8mm_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [i8mm_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic                                  pready,
    input  logic                                  start,
    input  logic                                  busy,
    input  i8mm_pkg::request_t                    request,
    input  logic                                  done,
    input  i8mm_pkg::result_t                     result,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    checked
);

    import i8mm_pkg::*;

    logic signed [ELEM_W-1:0] a_mem [MAX_ROWS*MAX_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [MAX_DEPTH*MAX_COLS];
    logic [4:0]               rows_cfg;
    logic [4:0]               cols_cfg;
    logic [6:0]               depth_cfg;
    result_t                  dot_sums_due [$];

    // Applies one transfer to the stores; returns 1 when it yields a result.
    function automatic bit gemm_dot(input request_t req, output result_t res);
        int unsigned rows;
        int unsigned cols;
        int unsigned depth;
        int unsigned m;
        int unsigned n;
        int unsigned k;
        longint      acc;
        rows  = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        cols  = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
        depth = (depth_cfg > MAX_DEPTH) ? MAX_DEPTH : depth_cfg;
        m     = req.row_index;
        n     = req.col_index;
        res   = '0;
        case (cmd_t'(req.command))
            CMD_LOAD_A:
            begin
                if (m < rows && n < depth)
                    a_mem[m*MAX_DEPTH+n] = req.element;
                return 1'b0;
            end
            CMD_LOAD_B:
            begin
                if (m < depth && n < cols)
                    b_mem[m*MAX_COLS+n] = req.element;
                return 1'b0;
            end
            CMD_COMPUTE:
            begin
                if (m < rows && n < cols)
                begin
                    acc = 0;
                    for (k = 0; k < depth; k++)
                        acc += longint'(a_mem[m*MAX_DEPTH+k]) * longint'(b_mem[k*MAX_COLS+n]);
                    if (acc > SUM_MAX)
                        acc = SUM_MAX;
                    if (acc < SUM_MIN)
                        acc = SUM_MIN;
                    res.dot_sum = SUM_W'(acc);
                end
                else
                begin
                    res.index_error = 1'b1;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t due;
        bit      bad;
        if (!rst_n)
        begin
            rows_cfg   = NUM_ROWS_RESET;
            cols_cfg   = NUM_COLS_RESET;
            depth_cfg  = INNER_DEPTH_RESET;
            dot_sums_due.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            bad = 1'b0;
            if (done)
            begin
                if (dot_sums_due.size() == 0)
                begin
                    $error("result: none expected, got dot_sum %0d index_error %0d",
                           result.dot_sum, result.index_error);
                    bad = 1'b1;
                end
                else
                begin
                    want = dot_sums_due.pop_front();
                    if (result.dot_sum !== want.dot_sum)
                    begin
                        $error("dot_sum: expected %0d, got %0d", want.dot_sum, result.dot_sum);
                        bad = 1'b1;
                    end
                    if (result.index_error !== want.index_error)
                    begin
                        $error("index_error: expected %0d, got %0d",
                               want.index_error, result.index_error);
                        bad = 1'b1;
                    end
                    checked <= checked + 1;
                end
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_NUM_ROWS:    rows_cfg  = pwdata[4:0];
                    REG_NUM_COLS:    cols_cfg  = pwdata[4:0];
                    REG_INNER_DEPTH: depth_cfg = pwdata[6:0];
                    default:         ;
                endcase
            end
            if (start && !busy)
            begin
                if (gemm_dot(request, due))
                    dot_sums_due.push_back(due);
            end
            if (bad)
                fail_count <= fail_count + 1;
            pending <= dot_sums_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import i8mm_pkg::*;

    localparam int ROWS_MAX  = 16;
    localparam int COLS_MAX  = 16;
    localparam int DEPTH_MAX = 64;
    localparam int SETTLE    = 64;
    localparam int LIMIT     = 1000000;
    localparam int WORK      = 1850;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    start;
    logic                    busy;
    request_t                request;
    logic                    done;
    result_t                 result;

    int                      fail_count;
    int                      pending;
    int                      checked;
    int                      cycle_count = 0;

    bit                      a_set [ROWS_MAX*DEPTH_MAX];
    bit                      b_set [DEPTH_MAX*COLS_MAX];
    int unsigned             rows_eff;
    int unsigned             cols_eff;
    int unsigned             depth_eff;
    bit                      calm;
    int                      work_items;
    int                      loads_sent;
    int                      computes_sent;
    int                      errors_sent;
    int                      ignored_sent;
    int                      settings;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[int8_matrix_multiply] ERROR");
            $finish;
        end
    end

    int8_matrix_multiply #(
        .MAX_ROWS  (ROWS_MAX),
        .MAX_COLS  (COLS_MAX),
        .MAX_DEPTH (DEPTH_MAX)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    i8mm_dot_checker #(
        .MAX_ROWS  (ROWS_MAX),
        .MAX_COLS  (COLS_MAX),
        .MAX_DEPTH (DEPTH_MAX)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_sizes(input int unsigned r, input int unsigned c, input int unsigned d);
        wait_quiet();
        write_reg(REG_NUM_ROWS, r);
        write_reg(REG_NUM_COLS, c);
        write_reg(REG_INNER_DEPTH, d);
        rows_eff  = ((r & 31) > ROWS_MAX) ? ROWS_MAX : (r & 31);
        cols_eff  = ((c & 31) > COLS_MAX) ? COLS_MAX : (c & 31);
        depth_eff = ((d & 127) > DEPTH_MAX) ? DEPTH_MAX : (d & 127);
        settings++;
    endtask

    task automatic send(input cmd_t cmd, input int unsigned row, input int unsigned col,
                        input logic signed [ELEM_W-1:0] elem);
        request_t    req;
        int unsigned m;
        int unsigned n;
        req.command   = cmd;
        req.row_index = INDEX_W'(row);
        req.col_index = INDEX_W'(col);
        req.element   = elem;
        m             = req.row_index;
        n             = req.col_index;
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        case (cmd)
            CMD_LOAD_A:
                if (m < rows_eff && n < depth_eff)
                begin
                    a_set[m*DEPTH_MAX+n] = 1'b1;
                    loads_sent++;
                    work_items++;
                end
                else
                    ignored_sent++;
            CMD_LOAD_B:
                if (m < depth_eff && n < cols_eff)
                begin
                    b_set[m*COLS_MAX+n] = 1'b1;
                    loads_sent++;
                    work_items++;
                end
                else
                    ignored_sent++;
            CMD_COMPUTE:
            begin
                computes_sent++;
                work_items++;
                if (m >= rows_eff || n >= cols_eff)
                    errors_sent++;
            end
            default:
                ignored_sent++;
        endcase
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    function automatic bit ready_at(input int unsigned m, input int unsigned n);
        int unsigned k;
        for (k = 0; k < depth_eff; k++)
            if (!a_set[m*DEPTH_MAX+k] || !b_set[k*COLS_MAX+n])
                return 1'b0;
        return 1'b1;
    endfunction

    // writes whatever row m of A and column n of B still lack, refreshing a few others
    task automatic prime(input int unsigned m, input int unsigned n);
        int unsigned k;
        for (k = 0; k < depth_eff; k++)
        begin
            if (!a_set[m*DEPTH_MAX+k] || $urandom_range(0, 7) == 0)
                send(CMD_LOAD_A, m, k, ELEM_W'($urandom));
            if (!b_set[k*COLS_MAX+n] || $urandom_range(0, 7) == 0)
                send(CMD_LOAD_B, k, n, ELEM_W'($urandom));
        end
    endtask

    task automatic random_phase(input int quota);
        int          target;
        int unsigned pick;
        int unsigned m;
        int unsigned n;
        int unsigned m2;
        int unsigned n2;
        int unsigned span;
        target = work_items + quota;
        while (work_items < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && rows_eff != 0 && cols_eff != 0)
            begin
                m = $urandom_range(0, rows_eff - 1);
                n = $urandom_range(0, cols_eff - 1);
                prime(m, n);
                repeat ($urandom_range(1, 4))
                begin
                    m2 = $urandom_range(0, rows_eff - 1);
                    n2 = $urandom_range(0, cols_eff - 1);
                    if (!ready_at(m2, n2))
                    begin
                        m2 = m;
                        n2 = n;
                    end
                    send(CMD_COMPUTE, m2, n2, ELEM_W'($urandom));
                end
            end
            else if (pick < 75)
            begin
                m = $urandom_range(0, 63);
                n = $urandom_range(0, 63);
                if (m < rows_eff && n < cols_eff && !ready_at(m, n))
                    prime(m, n);
                send(CMD_COMPUTE, m, n, ELEM_W'($urandom));
            end
            else if (pick < 92)
            begin
                span = $urandom_range(0, 1) ? 63 : 15;
                send($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                     $urandom_range(0, span), $urandom_range(0, span), ELEM_W'($urandom));
            end
            else
            begin
                send(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                     ELEM_W'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase_rows [12]  = '{16, 1, 31, 4, 16, 1, 8, 0, 2, 17, 16, 5};
        int unsigned phase_cols [12]  = '{16, 1, 31, 3, 1, 16, 8, 9, 16, 0, 16, 6};
        int unsigned phase_depth [12] = '{64, 1, 127, 5, 8, 16, 4, 3, 33, 7, 0, 65};
        int          p;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        start   <= 1'b0;
        request <= '0;
        calm      = 1'b0;
        rows_eff  = NUM_ROWS_RESET;
        cols_eff  = NUM_COLS_RESET;
        depth_eff = INNER_DEPTH_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner values at the matrix edges, ignored loads, idle command, bad positions, zero depth and zero sizes
        set_sizes(16, 16, 2);
        send(CMD_LOAD_A, 15, 0, -128);
        send(CMD_LOAD_A, 15, 1, -128);
        send(CMD_LOAD_B, 0, 15, -128);
        send(CMD_LOAD_B, 1, 15, -128);
        send(CMD_LOAD_A, 0, 0, 127);
        send(CMD_LOAD_A, 0, 1, 127);
        send(CMD_LOAD_B, 0, 0, -128);
        send(CMD_LOAD_B, 1, 0, 127);
        send(CMD_COMPUTE, 15, 15, 0);
        send(CMD_COMPUTE, 0, 0, 127);
        send(CMD_COMPUTE, 0, 15, -128);
        send(CMD_COMPUTE, 15, 0, -1);
        send(CMD_LOAD_A, 63, 0, 1);
        send(CMD_LOAD_A, 0, 2, 5);
        send(CMD_LOAD_B, 63, 63, -1);
        send(CMD_NONE, 63, 63, -1);
        send(CMD_COMPUTE, 16, 0, 0);
        send(CMD_COMPUTE, 0, 63, 0);
        send(CMD_COMPUTE, 63, 63, -1);
        set_sizes(16, 16, 0);
        send(CMD_COMPUTE, 0, 0, 0);
        set_sizes(0, 0, 2);
        send(CMD_COMPUTE, 0, 0, 0);

        for (p = 0; p < 12; p++)
        begin
            set_sizes(phase_rows[p], phase_cols[p], phase_depth[p]);
            if (p == 11)
                calm = 1'b1;
            random_phase((WORK - work_items) / (12 - p));
        end

        wait_quiet();
        $display("covered %0d loads, %0d computes (%0d out of range), %0d ignored transfers",
                 loads_sent, computes_sent, errors_sent, ignored_sent);
        $display("over %0d size settings; %0d dot sums checked, %0d failures",
                 settings, checked, fail_count);
        if (fail_count == 0)
            $display("[int8_matrix_multiply] OK");
        else
            $display("[int8_matrix_multiply] ERROR");
        $finish;
    end

endmodule
